[hw/rtl/dcc_enc_pkg.sv]
// ----------------------------------------------------------------------------
// dcc_enc_pkg
// Shared types and constants of the DCC locomotive packet encoder.
// ----------------------------------------------------------------------------
package dcc_enc_pkg;

    // command kinds
    localparam logic [2:0] KIND_SPEED  = 3'd0;
    localparam logic [2:0] KIND_FN0_4  = 3'd1;
    localparam logic [2:0] KIND_FN5_8  = 3'd2;
    localparam logic [2:0] KIND_FN9_12 = 3'd3;
    localparam logic [2:0] KIND_POM    = 3'd4;
    localparam logic [2:0] KIND_RESET  = 3'd5;
    localparam logic [2:0] KIND_IDLE   = 3'd6;

    // speed step modes, any other code runs as 128 steps
    localparam logic [1:0] MODE_14 = 2'd0;
    localparam logic [1:0] MODE_28 = 2'd1;

    // address and instruction byte constants
    localparam logic [13:0] SHORT_ADDR_LIMIT = 14'd100;
    localparam logic [7:0]  LONG_ADDR_MARK   = 8'hC0;
    localparam logic [7:0]  SPEED_BASE       = 8'h40;
    localparam logic [7:0]  SPEED128_BYTE    = 8'h3F;
    localparam logic [7:0]  FN0_4_BASE       = 8'h80;
    localparam logic [7:0]  FN5_8_BASE       = 8'hB0;
    localparam logic [7:0]  FN9_12_BASE      = 8'hA0;
    localparam logic [7:0]  POM_BASE         = 8'hEC;
    localparam logic [7:0]  IDLE_BYTE        = 8'hFF;

    // scaled speed steps: x*14/125 and x*28/125 as multiply and shift
    localparam int          RECIP_SHIFT = 20;
    localparam logic [17:0] RECIP_14    = 18'd117446;
    localparam logic [17:0] RECIP_28    = 18'd234892;

    // bit group shapes
    localparam int          PKT_BYTES      = 5;
    localparam logic [4:0]  PREAMBLE_COUNT = 5'd16;
    localparam logic [4:0]  BYTE_COUNT     = 5'd9;
    localparam logic [4:0]  CLOSE_COUNT    = 5'd10;
    localparam logic [15:0] PREAMBLE_BITS  = 16'hFFFF;

    // one locomotive command
    typedef struct packed {
        logic [2:0]  kind;
        logic [13:0] address;
        logic [7:0]  speed;
        logic [1:0]  speed_mode;
        logic [7:0]  fn_low;
        logic [7:0]  fn_high;
        logic [9:0]  pom_cv;
        logic [7:0]  pom_value;
    } cmd_t;

    // one bit group of the serial stream
    typedef struct packed {
        logic [15:0] bit_group;
        logic [4:0]  bit_count;
        logic        last;
    } grp_t;

    // packet bytes ready for serializing
    typedef struct packed {
        logic [PKT_BYTES-1:0][7:0] bytes;
        logic [2:0]                count;
        logic [7:0]                chk;
    } packet_t;

    // packet handoff between packer and serializer
    typedef struct packed {
        logic    valid;
        packet_t pkt;
    } pkt_req_t;

endpackage

[hw/rtl/dcc_enc_packer.sv]
// ----------------------------------------------------------------------------
// dcc_enc_packer
// Builds the packet bytes, byte count and XOR checksum of one command.
// ----------------------------------------------------------------------------
module dcc_enc_packer
    import dcc_enc_pkg::*;
(
    input  cmd_t    cmd,
    output packet_t pkt
);

    logic        is_long;
    logic [7:0]  addr0;
    logic [7:0]  addr1;
    logic [7:0]  ins0;
    logic [7:0]  ins1;
    logic [7:0]  ins2;
    logic [1:0]  ins_n;
    logic [6:0]  spd_v;
    logic [6:0]  spd_d;
    logic [24:0] prod14;
    logic [24:0] prod28;
    logic [4:0]  step14;
    logic [5:0]  step28;
    logic [3:0]  code14;
    logic [4:0]  code28;
    logic [7:0]  byte14;
    logic [7:0]  byte28;

    // address bytes
    assign is_long = (cmd.address >= SHORT_ADDR_LIMIT);
    assign addr0   = is_long ? (LONG_ADDR_MARK | {2'b00, cmd.address[13:8]})
                             : cmd.address[7:0];
    assign addr1   = cmd.address[7:0];

    // speed step scaling
    assign spd_v  = cmd.speed[6:0];
    assign spd_d  = spd_v - 7'd2;
    assign prod14 = 25'(spd_d) * 25'(RECIP_14);
    assign prod28 = 25'(spd_d) * 25'(RECIP_28);
    assign step14 = prod14[24:RECIP_SHIFT] + 5'd2;
    assign step28 = {1'b0, prod28[24:RECIP_SHIFT]} + 6'd4;

    // fourteen step code, saturated at the top step
    always_comb
    begin
        if (spd_v < 7'd2)
            code14 = spd_v[3:0];
        else if (step14 > 5'd15)
            code14 = 4'd15;
        else
            code14 = step14[3:0];
    end

    // twenty-eight step code, speed one maps to emergency stop code
    always_comb
    begin
        if (spd_v == 7'd0)
            code28 = 5'd0;
        else if (spd_v == 7'd1)
            code28 = 5'd2;
        else if (step28 > 6'd31)
            code28 = 5'd31;
        else
            code28 = step28[4:0];
    end

    assign byte14 = SPEED_BASE | {2'b00, cmd.speed[7], cmd.fn_low[0], code14};
    assign byte28 = SPEED_BASE | {2'b00, cmd.speed[7], code28[0], code28[4:1]};

    // instruction bytes, unused ones held at zero
    always_comb
    begin
        ins0  = 8'h00;
        ins1  = 8'h00;
        ins2  = 8'h00;
        ins_n = 2'd0;
        case (cmd.kind)
            KIND_SPEED:
            begin
                if (cmd.speed_mode == MODE_14)
                begin
                    ins0  = byte14;
                    ins_n = 2'd1;
                end
                else if (cmd.speed_mode == MODE_28)
                begin
                    ins0  = byte28;
                    ins_n = 2'd1;
                end
                else
                begin
                    ins0  = SPEED128_BYTE;
                    ins1  = cmd.speed;
                    ins_n = 2'd2;
                end
            end
            KIND_FN0_4:
            begin
                ins0  = FN0_4_BASE | {3'b000, cmd.fn_low[0], cmd.fn_low[4:1]};
                ins_n = 2'd1;
            end
            KIND_FN5_8:
            begin
                ins0  = FN5_8_BASE | {4'b0000, cmd.fn_high[0], cmd.fn_low[7:5]};
                ins_n = 2'd1;
            end
            KIND_FN9_12:
            begin
                ins0  = FN9_12_BASE | {4'b0000, cmd.fn_high[4:1]};
                ins_n = 2'd1;
            end
            KIND_POM:
            begin
                ins0  = POM_BASE | {6'b000000, cmd.pom_cv[9:8]};
                ins1  = cmd.pom_cv[7:0];
                ins2  = cmd.pom_value;
                ins_n = 2'd3;
            end
            default:
            begin
                ins_n = 2'd0;
            end
        endcase
    end

    // byte list and checksum
    always_comb
    begin
        if (cmd.kind == KIND_RESET || cmd.kind == KIND_IDLE)
        begin
            pkt.bytes[0] = (cmd.kind == KIND_IDLE) ? IDLE_BYTE : 8'h00;
            pkt.bytes[1] = 8'h00;
            pkt.bytes[2] = 8'h00;
            pkt.bytes[3] = 8'h00;
            pkt.bytes[4] = 8'h00;
            pkt.count    = 3'd2;
        end
        else if (is_long)
        begin
            pkt.bytes[0] = addr0;
            pkt.bytes[1] = addr1;
            pkt.bytes[2] = ins0;
            pkt.bytes[3] = ins1;
            pkt.bytes[4] = ins2;
            pkt.count    = 3'd2 + {1'b0, ins_n};
        end
        else
        begin
            pkt.bytes[0] = addr0;
            pkt.bytes[1] = ins0;
            pkt.bytes[2] = ins1;
            pkt.bytes[3] = ins2;
            pkt.bytes[4] = 8'h00;
            pkt.count    = 3'd1 + {1'b0, ins_n};
        end
        pkt.chk = pkt.bytes[0] ^ pkt.bytes[1] ^ pkt.bytes[2]
                ^ pkt.bytes[3] ^ pkt.bytes[4];
    end

endmodule

[hw/rtl/dcc_enc_serializer.sv]
// ----------------------------------------------------------------------------
// dcc_enc_serializer
// Holds one packet and sends preamble, byte groups and closing group, one
// group per cycle while grp_ready does not stall it, into a registered output stage.
// ----------------------------------------------------------------------------
module dcc_enc_serializer
    import dcc_enc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  pkt_req_t req,
    output logic     req_ready,
    output logic     grp_valid,
    input  logic     grp_ready,
    output grp_t     grp
);

    packet_t    pkt_reg;
    logic       pkt_valid_reg;
    logic [2:0] idx_reg;
    grp_t       grp_reg;
    logic       grp_valid_reg;

    logic       out_load;
    logic       emit;
    logic       is_close;
    logic [2:0] byte_idx;
    grp_t       grp_next;

    // group selection
    assign out_load = !grp_valid_reg || grp_ready;
    assign emit     = pkt_valid_reg && out_load;
    assign is_close = ({1'b0, idx_reg} == ({1'b0, pkt_reg.count} + 4'd1));
    assign byte_idx = idx_reg - 3'd1;

    always_comb
    begin
        if (idx_reg == 3'd0)
        begin
            grp_next.bit_group = PREAMBLE_BITS;
            grp_next.bit_count = PREAMBLE_COUNT;
            grp_next.last      = 1'b0;
        end
        else if (is_close)
        begin
            grp_next.bit_group = {7'b0000000, pkt_reg.chk, 1'b1};
            grp_next.bit_count = CLOSE_COUNT;
            grp_next.last      = 1'b1;
        end
        else
        begin
            grp_next.bit_group = {8'h00, pkt_reg.bytes[byte_idx]};
            grp_next.bit_count = BYTE_COUNT;
            grp_next.last      = 1'b0;
        end
    end

    // next packet is taken as the closing group of the current one leaves
    assign req_ready = !pkt_valid_reg || (emit && is_close);

    // packet register and group index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
        end
        else if (req.valid && req_ready)
        begin
            pkt_valid_reg <= 1'b1;
            idx_reg       <= 3'd0;
        end
        else if (emit)
        begin
            if (is_close)
                pkt_valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req_ready)
            pkt_reg <= req.pkt;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            grp_valid_reg <= 1'b0;
        else if (out_load)
            grp_valid_reg <= pkt_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            grp_reg <= grp_next;
    end

    assign grp_valid = grp_valid_reg;
    assign grp       = grp_reg;

    // group index never runs past the closing group
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid_reg |-> ({1'b0, idx_reg} <= ({1'b0, pkt_reg.count} + 4'd1)))
        else $error("group index past closing group");

    // a preamble emitted shows up as a sixteen bit group
    a_preamble: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && idx_reg == 3'd0) |=> (grp_valid_reg && grp_reg.bit_count == PREAMBLE_COUNT))
        else $error("preamble group missing");

    // closing group carries the end bit and ten bits
    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        (grp_valid_reg && grp_reg.last) |->
            (grp_reg.bit_count == CLOSE_COUNT && grp_reg.bit_group[0]))
        else $error("malformed closing group");

    // a packet is never replaced before its closing group left
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (pkt_valid_reg && !(emit && is_close)) |=> pkt_valid_reg)
        else $error("packet dropped before closing group");

endmodule

[hw/rtl/dcc_loco_packet_encoder_unit.sv]
// ----------------------------------------------------------------------------
// dcc_loco_packet_encoder_unit
// DCC locomotive packet encoder: one command in, its serial bit groups out.
// ----------------------------------------------------------------------------
// Each accepted command transaction yields a preamble group of sixteen ones,
// one nine bit group per packet byte (start bit 0 and the byte) and a ten bit
// closing group (0, XOR checksum, end bit 1) flagged by last: three to seven
// groups, the count of packet bytes plus two. Groups leave one per cycle
// from the serializer while grp_ready does not stall it, the serializer
// stepping through its packet register. A command is registered at the
// input, encoded into packet bytes in the following cycle and handed over
// as the previous packet's closing group leaves, so commands follow each
// other with no gap on the output. Bits go out highest counted bit first.
module dcc_loco_packet_encoder_unit
    import dcc_enc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic grp_valid,
    input  logic grp_ready,
    output grp_t grp
);

    cmd_t     cmd_reg;
    logic     cmd_valid_reg;
    packet_t  pkt;
    pkt_req_t req;
    logic     req_ready;

    // input register
    assign cmd_ready = !cmd_valid_reg || req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_valid_reg <= 1'b0;
        else if (cmd_ready)
            cmd_valid_reg <= cmd_valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
            cmd_reg <= cmd;
    end

    // packet building
    dcc_enc_packer u_packer
    (
        .cmd (cmd_reg),
        .pkt (pkt)
    );

    assign req.valid = cmd_valid_reg;
    assign req.pkt   = pkt;

    // serializing into bit groups
    dcc_enc_serializer u_serializer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_ready (req_ready),
        .grp_valid (grp_valid),
        .grp_ready (grp_ready),
        .grp       (grp)
    );

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for dcc_loco_packet_encoder_unit: locomotive commands in, DCC
// bit groups out, each group checked against a locally built packet stream.
// ----------------------------------------------------------------------------
// A directed set of commands covers every command kind, both address forms,
// the speed scaling edges and clamps in all step modes, the unused speed mode
// and the unused kind. Random commands follow in bursts, while the output
// side stalls on its own pattern, once for a long stretch so the block backs
// up, and once the input side pauses until the block has drained.
module tb;
    import dcc_enc_pkg::*;

    // codes the package leaves unnamed
    localparam logic [2:0] KIND_ADDR_ONLY = 3'd7;
    localparam logic [1:0] MODE_128       = 2'd2;
    localparam logic [1:0] MODE_UNUSED    = 2'd3;

    // ------------------------------------------------------------------------
    // expected bit group store and packet builder
    // ------------------------------------------------------------------------
    class dcc_stream_board;
        grp_t due_groups[$];
        int   errors;
        int   reports;

        // speed instruction byte, fourteen steps
        function logic [7:0] speed14_byte(logic [7:0] spd, logic f0);
            int v;
            v = int'(spd[6:0]);
            if (v >= 2)
            begin
                v = ((v - 2) * 14) / 125 + 2;
                if (v > 15)
                    v = 15;
            end
            return SPEED_BASE | {2'b00, spd[7], f0, v[3:0]};
        endfunction

        // speed instruction byte, twenty-eight steps
        function logic [7:0] speed28_byte(logic [7:0] spd);
            int c;
            c = int'(spd[6:0]);
            if (c == 1)
                c = 2;
            else if (c >= 2)
            begin
                c = ((c - 2) * 28) / 125 + 4;
                if (c > 31)
                    c = 31;
            end
            return SPEED_BASE | {2'b00, spd[7], c[0], c[4:1]};
        endfunction

        // build the packet of one command and queue its bit groups
        function void note_command(cmd_t c);
            logic [7:0] pkt[$];
            logic [7:0] chk;
            grp_t       g;
            chk = 8'h00;
            if (c.kind == KIND_RESET)
            begin
                pkt.push_back(8'h00);
                pkt.push_back(8'h00);
            end
            else if (c.kind == KIND_IDLE)
            begin
                pkt.push_back(IDLE_BYTE);
                pkt.push_back(8'h00);
            end
            else
            begin
                // short or long address
                if (c.address < SHORT_ADDR_LIMIT)
                    pkt.push_back(c.address[7:0]);
                else
                begin
                    pkt.push_back(LONG_ADDR_MARK | {2'b00, c.address[13:8]});
                    pkt.push_back(c.address[7:0]);
                end
                // instruction bytes
                case (c.kind)
                    KIND_SPEED:
                    begin
                        if (c.speed_mode == MODE_14)
                            pkt.push_back(speed14_byte(c.speed, c.fn_low[0]));
                        else if (c.speed_mode == MODE_28)
                            pkt.push_back(speed28_byte(c.speed));
                        else
                        begin
                            pkt.push_back(SPEED128_BYTE);
                            pkt.push_back(c.speed);
                        end
                    end
                    KIND_FN0_4:
                        pkt.push_back(FN0_4_BASE | {3'b000, c.fn_low[0], c.fn_low[4:1]});
                    KIND_FN5_8:
                        pkt.push_back(FN5_8_BASE | {4'h0, c.fn_high[0], c.fn_low[7:5]});
                    KIND_FN9_12:
                        pkt.push_back(FN9_12_BASE | {4'h0, c.fn_high[4:1]});
                    KIND_POM:
                    begin
                        pkt.push_back(POM_BASE | {6'b000000, c.pom_cv[9:8]});
                        pkt.push_back(c.pom_cv[7:0]);
                        pkt.push_back(c.pom_value);
                    end
                    default:
                    begin
                    end
                endcase
            end
            // preamble, byte groups, closing group
            g.bit_group = PREAMBLE_BITS;
            g.bit_count = PREAMBLE_COUNT;
            g.last      = 1'b0;
            due_groups.push_back(g);
            foreach (pkt[i])
            begin
                chk         = chk ^ pkt[i];
                g.bit_group = {8'h00, pkt[i]};
                g.bit_count = BYTE_COUNT;
                g.last      = 1'b0;
                due_groups.push_back(g);
            end
            g.bit_group = {7'b0000000, chk, 1'b1};
            g.bit_count = CLOSE_COUNT;
            g.last      = 1'b1;
            due_groups.push_back(g);
        endfunction

        function void flag(string what, int unsigned want, int unsigned got);
            errors++;
            reports++;
            if (reports <= 100)
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, what, want, got);
        endfunction

        // compare one output transaction with the oldest expected group
        function void check_group(grp_t g);
            grp_t want;
            if (due_groups.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected group, expected none, actual 0x%0h/%0d/%0b",
                         $time, g.bit_group, g.bit_count, g.last);
                return;
            end
            want = due_groups.pop_front();
            if (g.bit_group !== want.bit_group)
                flag("bit_group", 32'(want.bit_group), 32'(g.bit_group));
            if (g.bit_count !== want.bit_count)
                flag("bit_count", 32'(want.bit_count), 32'(g.bit_count));
            if (g.last !== want.last)
                flag("last", 32'(want.last), 32'(g.last));
        endfunction

        function int outstanding();
            return due_groups.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block
    // ------------------------------------------------------------------------
    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    cmd_t cmd       = '0;
    logic grp_valid;
    logic grp_ready = 1'b0;
    grp_t grp;

    dcc_stream_board board = new();
    int              hold_off_left = 0;
    int              burst_left = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    dcc_loco_packet_encoder_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .grp_valid (grp_valid),
        .grp_ready (grp_ready),
        .grp       (grp)
    );

    // ------------------------------------------------------------------------
    // command side
    // ------------------------------------------------------------------------
    function automatic cmd_t make_cmd(logic [2:0] kind, logic [13:0] addr,
                                      logic [7:0] spd, logic [1:0] mode,
                                      logic [7:0] fl, logic [7:0] fh,
                                      logic [9:0] cv, logic [7:0] val);
        cmd_t c;
        c.kind       = kind;
        c.address    = addr;
        c.speed      = spd;
        c.speed_mode = mode;
        c.fn_low     = fl;
        c.fn_high    = fh;
        c.pom_cv     = cv;
        c.pom_value  = val;
        return c;
    endfunction

    // random command, mostly addressed commands, some broadcast and unused
    function automatic cmd_t random_cmd();
        cmd_t c;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            c.kind = KIND_SPEED;
        else if (pick < 42)
            c.kind = KIND_FN0_4;
        else if (pick < 52)
            c.kind = KIND_FN5_8;
        else if (pick < 62)
            c.kind = KIND_FN9_12;
        else if (pick < 80)
            c.kind = KIND_POM;
        else if (pick < 87)
            c.kind = KIND_RESET;
        else if (pick < 94)
            c.kind = KIND_IDLE;
        else
            c.kind = KIND_ADDR_ONLY;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            c.address = 14'($urandom_range(0, 99));
        else if (pick == 4)
            c.address = 14'($urandom_range(95, 105));
        else
            c.address = 14'($urandom_range(0, 16383));
        c.speed      = 8'($urandom_range(0, 255));
        c.speed_mode = 2'($urandom_range(0, 3));
        c.fn_low     = 8'($urandom_range(0, 255));
        c.fn_high    = 8'($urandom_range(0, 255));
        c.pom_cv     = 10'($urandom_range(0, 1023));
        c.pom_value  = 8'($urandom_range(0, 255));
        return c;
    endfunction

    // offer one command and hold it until the block takes it
    task automatic send_command(cmd_t c);
        cmd       <= c;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cmd_ready);
        board.note_command(c);
    endtask

    // random command inside a burst, with a gap once the burst runs out
    task automatic send_bursty(cmd_t c);
        if (burst_left == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(1, 25);
        end
        burst_left--;
        send_command(c);
    endtask

    // ------------------------------------------------------------------------
    // group side: sample the transaction, then pick the next ready
    // ------------------------------------------------------------------------
    initial
    begin
        int  rcv_cycle;
        int  style;
        logic nxt;
        rcv_cycle = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && grp_valid && grp_ready)
                board.check_group(grp);
            style = (rcv_cycle / 64) % 3;
            if (hold_off_left > 0)
            begin
                nxt = 1'b0;
                hold_off_left--;
            end
            else if (style == 0)
                nxt = 1'b1;
            else if (style == 1)
                nxt = 1'($urandom_range(0, 1));
            else
                nxt = ((rcv_cycle % 5) == 0) || ((rcv_cycle % 7) == 3);
            grp_ready <= nxt;
            rcv_cycle++;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // speed scaling edges and clamps in every step mode
        send_command(make_cmd(KIND_SPEED, 14'd3, 8'h00, MODE_14, 8'h00, 8'h00, 10'd0, 8'h00));
        send_command(make_cmd(KIND_SPEED, 14'd0, 8'h81, MODE_14, 8'h01, 8'h00, 10'd0, 8'h00));
        send_command(make_cmd(KIND_SPEED, 14'd99, 8'h82, MODE_14, 8'h00, 8'hFF, 10'd0, 8'h00));
        send_command(make_cmd(KIND_SPEED, 14'd100, 8'hFF, MODE_14, 8'hFF, 8'h00, 10'd0, 8'h00));
        send_command(make_cmd(KIND_SPEED, 14'd16383, 8'h00, MODE_28, 8'hFF, 8'hFF,
                              10'd1023, 8'hFF));
        send_command(make_cmd(KIND_SPEED, 14'd5, 8'h81, MODE_28, 8'h00, 8'h00, 10'd0, 8'h00));
        send_command(make_cmd(KIND_SPEED, 14'd5, 8'h02, MODE_28, 8'h00, 8'h00, 10'd0, 8'h00));
        send_command(make_cmd(KIND_SPEED, 14'd1234, 8'hFF, MODE_28, 8'h00, 8'h00,
                              10'd0, 8'h00));
        send_command(make_cmd(KIND_SPEED, 14'd42, 8'hA5, MODE_128, 8'h00, 8'h00, 10'd0, 8'h00));
        // unused speed mode runs as 128 steps
        send_command(make_cmd(KIND_SPEED, 14'd300, 8'h7F, MODE_UNUSED, 8'h00, 8'h00,
                              10'd0, 8'h00));
        // function groups, all on and all off
        send_command(make_cmd(KIND_FN0_4, 14'd7, 8'h00, MODE_14, 8'hFF, 8'h00, 10'd0, 8'h00));
        send_command(make_cmd(KIND_FN0_4, 14'd16383, 8'hFF, MODE_14, 8'h00, 8'hFF,
                              10'd0, 8'h00));
        send_command(make_cmd(KIND_FN5_8, 14'd8, 8'h00, MODE_14, 8'hE0, 8'h01, 10'd0, 8'h00));
        send_command(make_cmd(KIND_FN5_8, 14'd200, 8'h00, MODE_14, 8'h1F, 8'hFE, 10'd0, 8'h00));
        send_command(make_cmd(KIND_FN9_12, 14'd9, 8'h00, MODE_14, 8'h00, 8'h1E, 10'd0, 8'h00));
        send_command(make_cmd(KIND_FN9_12, 14'd9999, 8'h00, MODE_14, 8'hFF, 8'hE1,
                              10'd0, 8'h00));
        // programming on main, extremes of cv and value
        send_command(make_cmd(KIND_POM, 14'd3, 8'h00, MODE_14, 8'h00, 8'h00, 10'd1023, 8'hFF));
        send_command(make_cmd(KIND_POM, 14'd16383, 8'h00, MODE_14, 8'h00, 8'h00, 10'd0, 8'h00));
        // broadcast packets ignore every other field
        send_command(make_cmd(KIND_RESET, 14'd16383, 8'hFF, MODE_UNUSED, 8'hFF, 8'hFF,
                              10'd1023, 8'hFF));
        send_command(make_cmd(KIND_IDLE, 14'd50, 8'h12, MODE_28, 8'h34, 8'h56,
                              10'd345, 8'h78));
        // unused kind: address bytes only
        send_command(make_cmd(KIND_ADDR_ONLY, 14'd12, 8'h00, MODE_14, 8'h00, 8'h00,
                              10'd0, 8'h00));
        send_command(make_cmd(KIND_ADDR_ONLY, 14'd16000, 8'h00, MODE_14, 8'h00, 8'h00,
                              10'd0, 8'h00));

        // random commands
        for (int n = 0; n < 108; n++)
        begin
            // long output stall while commands keep coming
            if (n == 40)
                hold_off_left = 300;
            // let the block drain completely once
            if (n == 90)
            begin
                cmd_valid <= 1'b0;
                while (board.outstanding() != 0)
                    @(posedge clk);
                burst_left = $urandom_range(1, 25);
            end
            send_bursty(random_cmd());
        end
        cmd_valid <= 1'b0;

        // drain and settle
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (board.errors == 0 && board.outstanding() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
